// ===== rtl/core/lpfr_pkg.sv =====
// Shared types and constants for the length-prefixed frame receiver
package lpfr_pkg;

  // receive phase
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // error codes
  typedef enum logic [1:0] {
    ERR_NOISE   = 2'd0,
    ERR_LENGTH  = 2'd1,
    ERR_TIMEOUT = 2'd2
  } err_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_START_BYTE   = 2'd0,
    REG_NOISE_BUDGET = 2'd1,
    REG_MAX_PAYLOAD  = 2'd2
  } reg_idx_e;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned BYTE_W    = 8;

  localparam logic [BYTE_W-1:0] START_BYTE_RST   = 8'd170;
  localparam logic [BYTE_W-1:0] NOISE_BUDGET_RST = 8'd16;
  localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST  = 8'd255;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] noise_budget;
    logic [BYTE_W-1:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] payload;
    logic              last;
    err_e              error_code;
  } result_t;

endpackage

// ===== rtl/core/length_prefixed_frame_receiver_top.sv =====
// Top level of the start-byte, length-prefixed frame receiver
// path: input register, parse step, result register toward the master side
// throughput: one input transaction per cycle, set by the combinational parse step
// between the input register and the result register; stalls only on master backpressure
// reset: hunting phase, start byte 170, noise budget 16, max payload 255, no result pending
module length_prefixed_frame_receiver_top import lpfr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // slave side
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
  input  logic                 s_axis_tuser,   // [0] command
  // master side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // [7:0] payload, [9:8] error_code, rest zero
  output logic                 m_axis_tlast,   // last
  output logic [1:0]           m_axis_tuser,   // [1:0] kind
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [BYTE_W-1:0]    cfg_data_i
);

  cfg_t    cfg;
  logic    noise_load;
  item_t   in_item, held_item;
  logic    held_valid;
  logic    out_free;
  logic    advance;
  logic    res_valid;
  result_t res, out_res;

  assign cfg_ready_o = 1'b1;

  lpfr_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (cfg_valid_i),
    .idx_i        (cfg_index_i),
    .data_i       (cfg_data_i),
    .cfg_o        (cfg),
    .noise_load_o (noise_load)
  );

  assign in_item.command = s_axis_tuser;
  assign in_item.rx_byte = s_axis_tdata;

  // held transaction is parsed when the result slot can take its outcome
  assign advance = held_valid && out_free;

  lpfr_in_reg u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  lpfr_deframe u_deframe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .item_i        (held_item),
    .cfg_i         (cfg),
    .noise_load_i  (noise_load),
    .noise_value_i (cfg_data_i),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  lpfr_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .ready_i (m_axis_tready),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res)
  );

  // result packing
  assign m_axis_tdata = {6'd0, out_res.error_code, out_res.payload};
  assign m_axis_tlast = out_res.last;
  assign m_axis_tuser = out_res.kind;

endmodule

// ===== rtl/core/lpfr_cfg_regs.sv =====
// Configuration register file with noise budget reload strobe
module lpfr_cfg_regs import lpfr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  logic [CFG_IDX_W-1:0] idx_i,
  input  logic [BYTE_W-1:0]    data_i,
  output cfg_t                 cfg_o,
  output logic                 noise_load_o
);

  cfg_t cfg_q, cfg_d;

  // register decode
  always_comb begin
    cfg_d        = cfg_q;
    noise_load_o = 1'b0;
    if (wr_i) begin
      case (idx_i)
        REG_START_BYTE:   cfg_d.start_byte = data_i;
        REG_NOISE_BUDGET: begin
          cfg_d.noise_budget = data_i;
          noise_load_o       = 1'b1;
        end
        REG_MAX_PAYLOAD:  cfg_d.max_payload = data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte   <= START_BYTE_RST;
      cfg_q.noise_budget <= NOISE_BUDGET_RST;
      cfg_q.max_payload  <= MAX_PAYLOAD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/lpfr_in_reg.sv =====
// Input register stage holding one received transaction
module lpfr_in_reg import lpfr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // take a new transaction when empty or when the held one moves on
  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/lpfr_deframe.sv =====
// Frame parser: phase, noise counter and payload length tracking
module lpfr_deframe import lpfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  item_t             item_i,
  input  cfg_t              cfg_i,
  input  logic              noise_load_i,
  input  logic [BYTE_W-1:0] noise_value_i,
  output logic              res_valid_o,
  output result_t           res_o
);

  phase_e            phase_q, phase_d;
  logic [BYTE_W-1:0] noise_left_q, noise_left_d;
  logic [BYTE_W-1:0] remain_q, remain_d;
  logic              fin;

  assign fin = (remain_q <= 8'd1);

  // next state and result
  always_comb begin
    phase_d          = phase_q;
    noise_left_d     = noise_left_q;
    remain_d         = remain_q;
    res_valid_o      = 1'b0;
    res_o.kind       = KIND_BYTE;
    res_o.payload    = '0;
    res_o.last       = 1'b0;
    res_o.error_code = ERR_NOISE;

    if (step_i) begin
      if (item_i.command) begin
        // read timeout in any phase
        phase_d          = PH_HUNT;
        noise_left_d     = cfg_i.noise_budget;
        remain_d         = '0;
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_ERROR;
        res_o.error_code = ERR_TIMEOUT;
      end else begin
        case (phase_q)
          PH_LEN: begin
            if (item_i.rx_byte > cfg_i.max_payload) begin
              phase_d          = PH_HUNT;
              noise_left_d     = cfg_i.noise_budget;
              remain_d         = '0;
              res_valid_o      = 1'b1;
              res_o.kind       = KIND_ERROR;
              res_o.error_code = ERR_LENGTH;
            end else if (item_i.rx_byte == '0) begin
              // empty frame
              phase_d      = PH_HUNT;
              noise_left_d = cfg_i.noise_budget;
              remain_d     = '0;
              res_valid_o  = 1'b1;
              res_o.kind   = KIND_EMPTY;
              res_o.last   = 1'b1;
            end else begin
              remain_d = item_i.rx_byte;
              phase_d  = PH_DATA;
            end
          end
          PH_DATA: begin
            res_valid_o   = 1'b1;
            res_o.kind    = KIND_BYTE;
            res_o.payload = item_i.rx_byte;
            res_o.last    = fin;
            if (fin) begin
              remain_d     = '0;
              phase_d      = PH_HUNT;
              noise_left_d = cfg_i.noise_budget;
            end else begin
              remain_d = remain_q - 8'd1;
            end
          end
          default: begin
            // hunting, also the unused phase code
            phase_d = PH_HUNT;
            if (item_i.rx_byte == cfg_i.start_byte) begin
              phase_d      = PH_LEN;
              noise_left_d = cfg_i.noise_budget;
            end else if (noise_left_q <= 8'd1) begin
              noise_left_d     = cfg_i.noise_budget;
              remain_d         = '0;
              res_valid_o      = 1'b1;
              res_o.kind       = KIND_ERROR;
              res_o.error_code = ERR_NOISE;
            end else begin
              noise_left_d = noise_left_q - 8'd1;
            end
          end
        endcase
      end
    end

    // a budget write reloads the counter at once with the written value
    if (noise_load_i) begin
      noise_left_d = noise_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      noise_left_q <= NOISE_BUDGET_RST;
      remain_q     <= '0;
    end else begin
      phase_q      <= phase_d;
      noise_left_q <= noise_left_d;
      remain_q     <= remain_d;
    end
  end

endmodule

// ===== rtl/core/lpfr_out_reg.sv =====
// Output result register toward the master side
module lpfr_out_reg import lpfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    ready_i,
  output logic    free_o,
  output logic    valid_o,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // slot is free when empty or being drained this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
